// ===== hw/rtl/c2d_pkg.sv =====
// shared types, sizes and the filter weight rom for the 4x4 convolution stream
// no dependencies; every other file of the block refers to it by scoped names
package c2d_pkg;

    localparam int IMAGE_WIDTH_DEF = 28;
    localparam int KERNEL_SIDE     = 4;
    localparam int FILTER_COUNT    = 8;
    localparam int TAP_COUNT       = KERNEL_SIDE * KERNEL_SIDE;
    localparam int PIXEL_W         = 16;
    localparam int WEIGHT_W        = 16;
    localparam int PROD_W          = PIXEL_W + WEIGHT_W;
    localparam int PART_W          = PROD_W + 2;
    localparam int SUM_W           = PART_W + 2;
    localparam int FILT_W          = 3;
    localparam int GROUP_COUNT     = TAP_COUNT / KERNEL_SIDE;
    localparam int QUEUE_DEPTH     = 2;

    typedef logic signed [PIXEL_W-1:0] t_pixel;

    // tap r*KERNEL_SIDE+c is window row r, column c; row 0 is the oldest
    typedef logic [TAP_COUNT-1:0][PIXEL_W-1:0] t_window;

    typedef struct packed {
        t_window win;
        logic    frame_end;
    } t_job;

    // Q1.15 weights, [filter][row * KERNEL_SIDE + column]
    localparam int WEIGHT_ROM [FILTER_COUNT][TAP_COUNT] = '{
        '{  9129,  -1396,  -7432, -17370,   1049,  20516,   3254, -25543,
           -3323,  18366,  18140,  -6904, -17865,  11125,  10204, -15090 },
        '{ -7003, -11790, -24750,  -7412,  -1229,  -2569, -10945,  -8834,
           -1304,   2310,  11023,  17249,  -2366,   -744,  22132,  16558 },
        '{ -2474,  -8674,  -3002,  24871,   9906,   3264, -18963, -13363,
           -7386,  15922,  -4696, -15077,  -8684,  16302,   7766,   1609 },
        '{  -691,   4909,   6753,  10561,  -6737,  -6685,  -7022,  -3414,
           -4945,  -5931,   -590,  -9490, -10024,  -4791,  -4542,  -2451 },
        '{  4905,   3922,   5158,   8317,   9765,   8759,  12665,   6495,
            3192,  -3159,   4175,   3061,  -6101,  -2648, -11089,  -6672 },
        '{ -7340, -15840, -15489,  -1144,  16915,   4348,   -908, -10034,
            7265,  11731,  -1373,  -4047, -13238,   6039,  12514,  11420 },
        '{  6599,  17003,  13209,  -1645,  10846,  10732,  -6947, -12213,
           10047,  -9598, -12871,  -8697,  -3958,  -9306,  -3775,  -4230 },
        '{ 11944,   8244,   3024, -14310, -17259,   1307,  25811, -10682,
          -15919,  -7540,  13392,  14352,   6524,  -5223, -19107,   5997 }
    };

endpackage

// ===== hw/rtl/c2d_front.sv =====
// front end: pixel intake, raster counters, column line buffer and 4x4 window
// uses c2d_pkg; pushes complete windows into c2d_queue
module c2d_front #(
    parameter int IMAGE_WIDTH = c2d_pkg::IMAGE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pixel_valid,
    output logic              o_pixel_ready,
    input  logic [15:0]       i_pixel,
    output logic              o_push,
    output c2d_pkg::t_job     o_job,
    input  logic              i_queue_full
);

    localparam int CNT_W  = $clog2(IMAGE_WIDTH);
    localparam int KS     = c2d_pkg::KERNEL_SIDE;
    localparam int PW     = c2d_pkg::PIXEL_W;
    localparam int WORD_W = (KS - 1) * PW;
    localparam int VEC_W  = KS * PW;

    // one word per column: the three previous rows at that column, newest low
    logic [WORD_W-1:0] r_mem [IMAGE_WIDTH];

    logic [CNT_W-1:0]  r_col;
    logic [CNT_W-1:0]  r_row;
    logic              r_b_valid;
    logic [CNT_W-1:0]  r_b_col;
    logic [PW-1:0]     r_b_pixel;
    logic              r_b_emit;
    logic              r_b_frame_end;
    logic [WORD_W-1:0] r_rd_data;
    logic [VEC_W-1:0]  r_win_col [KS];

    logic              accept;
    logic              b_go;
    logic              last_col;
    logic              last_row;
    logic [VEC_W-1:0]  new_col;
    logic [VEC_W-1:0]  n_win_col [KS];

    assign accept        = i_pixel_valid && o_pixel_ready;
    assign b_go          = r_b_valid && (!r_b_emit || !i_queue_full);
    assign o_pixel_ready = !r_b_valid || b_go;
    assign last_col      = (r_col == CNT_W'(IMAGE_WIDTH - 1));
    assign last_row      = (r_row == CNT_W'(IMAGE_WIDTH - 1));
    assign new_col       = {r_rd_data, r_b_pixel};

    always_comb begin
        for (int c = 0; c < KS - 1; c++) begin
            n_win_col[c] = r_win_col[c + 1];
        end
        n_win_col[KS-1] = new_col;
    end

    always_comb begin
        for (int r = 0; r < KS; r++) begin
            for (int c = 0; c < KS; c++) begin
                o_job.win[r*KS + c] = n_win_col[c][(KS-1-r)*PW +: PW];
            end
        end
        o_job.frame_end = r_b_frame_end;
    end

    assign o_push = b_go && r_b_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_b_valid <= 1'b1;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_col       <= r_col;
            r_b_pixel     <= i_pixel;
            r_b_emit      <= (r_row >= CNT_W'(KS - 1)) && (r_col >= CNT_W'(KS - 1));
            r_b_frame_end <= last_row && last_col;
            r_rd_data     <= r_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_mem[r_b_col] <= {r_rd_data[WORD_W-PW-1:0], r_b_pixel};
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            for (int c = 0; c < KS; c++) begin
                r_win_col[c] <= n_win_col[c];
            end
        end
    end

endmodule

// ===== hw/rtl/c2d_queue.sv =====
// two-entry queue of windows between the front end and the mac engine
// uses c2d_pkg for the entry type and depth
module c2d_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  c2d_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output c2d_pkg::t_job o_job,
    output logic          o_empty
);

    localparam int DEPTH = c2d_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    c2d_pkg::t_job    r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("window pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("window popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== hw/rtl/c2d_back.sv =====
// mac engine: one filter per cycle unless stalled or idle; 16 multiplier lanes and
// a two-level adder tree. Weight rom, widths from c2d_pkg; windows from c2d_queue
module c2d_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  c2d_pkg::t_job       i_job,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_result_valid,
    input  logic                i_result_ready,
    output logic signed [35:0]  o_feature_sum,
    output logic [2:0]          o_filter_index,
    output logic                o_last_of_pixel,
    output logic                o_last_of_frame
);

    localparam int TAPS   = c2d_pkg::TAP_COUNT;
    localparam int GROUPS = c2d_pkg::GROUP_COUNT;
    localparam int GSIZE  = TAPS / GROUPS;
    localparam int FW     = c2d_pkg::FILT_W;
    localparam int PRW    = c2d_pkg::PROD_W;
    localparam int PAW    = c2d_pkg::PART_W;
    localparam int SW     = c2d_pkg::SUM_W;
    localparam int WW     = c2d_pkg::WEIGHT_W;

    logic [FW-1:0]          r_filt;
    logic                   en;
    logic                   issue;
    logic                   issue_last;

    // stage 1: products
    logic                   r_s1_valid;
    logic [FW-1:0]          r_s1_filt;
    logic                   r_s1_last;
    logic                   r_s1_frame;
    logic signed [PRW-1:0]  r_prod [TAPS];
    logic signed [PRW-1:0]  n_prod [TAPS];

    // stage 2: partial sums of one window row each
    logic                   r_s2_valid;
    logic [FW-1:0]          r_s2_filt;
    logic                   r_s2_last;
    logic                   r_s2_frame;
    logic signed [PAW-1:0]  r_part [GROUPS];
    logic signed [PAW-1:0]  n_part [GROUPS];

    // stage 3: output register
    logic                   r_s3_valid;
    logic [FW-1:0]          r_s3_filt;
    logic                   r_s3_last;
    logic                   r_s3_frame;
    logic signed [SW-1:0]   r_sum;
    logic signed [SW-1:0]   n_sum;

    // the whole pipeline moves as one whenever the output slot is free
    assign en         = !r_s3_valid || i_result_ready;
    assign issue      = en && !i_empty;
    assign issue_last = (r_filt == FW'(c2d_pkg::FILTER_COUNT - 1));
    assign o_pop      = issue && issue_last;

    always_comb begin
        logic signed [WW-1:0] w_tap;
        for (int t = 0; t < TAPS; t++) begin
            w_tap     = WW'(c2d_pkg::WEIGHT_ROM[r_filt][t]);
            n_prod[t] = $signed(i_job.win[t]) * w_tap;
        end
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_part[g] = '0;
            for (int k = 0; k < GSIZE; k++) begin
                n_part[g] = n_part[g] + PAW'(r_prod[g*GSIZE + k]);
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            n_sum = n_sum + SW'(r_part[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            if (issue) begin
                r_filt <= r_filt + 1'b1;
            end
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_filt  <= r_filt;
            r_s1_last  <= issue_last;
            r_s1_frame <= issue_last && i_job.frame_end;
            for (int t = 0; t < TAPS; t++) begin
                r_prod[t] <= n_prod[t];
            end
            r_s2_filt  <= r_s1_filt;
            r_s2_last  <= r_s1_last;
            r_s2_frame <= r_s1_frame;
            for (int g = 0; g < GROUPS; g++) begin
                r_part[g] <= n_part[g];
            end
            r_s3_filt  <= r_s2_filt;
            r_s3_last  <= r_s2_last;
            r_s3_frame <= r_s2_frame;
            r_sum      <= n_sum;
        end
    end

    assign o_result_valid  = r_s3_valid;
    assign o_feature_sum   = r_sum;
    assign o_filter_index  = r_s3_filt;
    assign o_last_of_pixel = r_s3_last;
    assign o_last_of_frame = r_s3_frame;

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("window retired with queue empty");

    a_last_matches_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_last_of_pixel == (o_filter_index == FW'(c2d_pkg::FILTER_COUNT - 1))))
        else $error("last_of_pixel not on the final filter");

    a_frame_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_of_frame) |-> o_last_of_pixel)
        else $error("last_of_frame without last_of_pixel");

endmodule

// ===== hw/rtl/conv2d_4x4_eight_filter_stream_top.sv =====
// top level of the streaming 4x4 convolution with eight fixed filters
// uses c2d_pkg, c2d_front, c2d_queue and c2d_back
//
// Takes a square single-channel image of IMAGE_WIDTH x IMAGE_WIDTH Q2.14 pixels
// in raster order and, for every pixel whose row and column are both at least 3,
// returns eight Q7.29 window sums, one per filter in filter order, flagging the
// eighth with last_of_pixel and the very last of the image with last_of_frame.
// A pixel that completes no window is never pushed into the queue; a pixel that
// completes a window yields eight results on the single result port, issued by
// the mac engine at one filter per cycle whenever the output slot is free. A
// two-window queue lets the line buffer keep taking pixels while results are
// stalled. The first result of a window pixel passes the front-end register, a
// queue entry and the product, partial-sum and output registers before it is
// offered. No clearing pass is needed after reset.
module conv2d_4x4_eight_filter_stream_top #(
    parameter int IMAGE_WIDTH = c2d_pkg::IMAGE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pixel_valid,
    output logic               o_pixel_ready,
    input  logic signed [15:0] i_pixel,
    output logic               o_result_valid,
    input  logic               i_result_ready,
    output logic signed [35:0] o_feature_sum,
    output logic [2:0]         o_filter_index,
    output logic               o_last_of_pixel,
    output logic               o_last_of_frame
);

    logic          push;
    logic          pop;
    logic          queue_full;
    logic          queue_empty;
    c2d_pkg::t_job front_job;
    c2d_pkg::t_job head_job;

    c2d_front #(
        .IMAGE_WIDTH (IMAGE_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_pixel       (i_pixel),
        .o_push        (push),
        .o_job         (front_job),
        .i_queue_full  (queue_full)
    );

    c2d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (queue_empty)
    );

    c2d_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (head_job),
        .i_empty         (queue_empty),
        .o_pop           (pop),
        .o_result_valid  (o_result_valid),
        .i_result_ready  (i_result_ready),
        .o_feature_sum   (o_feature_sum),
        .o_filter_index  (o_filter_index),
        .o_last_of_pixel (o_last_of_pixel),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule
